// File: design/rrd_pkg.sv
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared types and constants for the Rice residual decoder: state machine
// codes, status codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package rrd_pkg;

    // Fixed widths of the payload state
    localparam int unsigned CNT_W   = 21;
    localparam int unsigned ACC_W   = 30;
    localparam int unsigned BSEEN_W = 30;

    localparam logic [4:0]         RICE_MAX   = 5'd30;
    localparam logic [BSEEN_W-1:0] BSEEN_MAX  = {BSEEN_W{1'b1}};
    localparam int unsigned        CNT_MAX    = (1 << CNT_W) - 1;

    // Register indexes on the configuration port (paddr[3:2])
    localparam logic [1:0] REG_RICE_PARAM = 2'd0;
    localparam logic [1:0] REG_RES_COUNT  = 2'd1;
    localparam logic [1:0] REG_BIT_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BITS,
        S_FLUSH,
        S_STATUS
    } state_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_LENGTH     = 3'd1,
        ST_TRUNC      = 3'd2,
        ST_QOVF       = 3'd3,
        ST_UNCONSUMED = 3'd4,
        ST_PADDING    = 3'd5
    } status_t;

endpackage

// File: design/rice_residual_decoder.sv
// ----------------------------------------------------------------------------
// rice_residual_decoder
// Bit-serial Rice decoder with zigzag mapping and end-of-payload status.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one payload byte per item in s_tdata, s_tlast marks the
//   final byte. Master stream: one result per item; m_tdata carries the
//   signed residual, m_tuser the status flag and code, m_tlast marks the
//   final result caused by an input byte.
//   Registers (rice parameter, residual count, valid bit count) sit on the
//   APB port and must be written between payload bytes; not enforced.
//   Sequence: each byte is accepted, then up to eight bits are read (one
//   payload bit per cycle through the unary/remainder sequencer while a new
//   result has somewhere to go), then flushed; the final byte adds a status
//   result. A new byte is accepted only once the last one is through.
//   Latency: a residual leaves one result behind its code's final bit, as
//   it waits for the next result or the byte's end (m_tlast if no status).
//   Reset clears the registers and the per-payload state; no clearing pass.
//   A stalled receiver holds the output register; the bit sequencer stops
//   only when a new result has nowhere to go.
// ----------------------------------------------------------------------------
module rice_residual_decoder
    import rrd_pkg::*;
#(
    parameter int unsigned MAX_RESIDUALS = 1048576
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] payload_byte
    input  logic        s_tlast,    // last_byte
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] residual
    output logic [3:0]  m_tuser,    // [0] is_status, [3:1] status
    output logic        m_tlast,    // last_result
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned     MAX_CLIP = (MAX_RESIDUALS > CNT_MAX) ? CNT_MAX : MAX_RESIDUALS;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CLIP);

    // configuration registers
    logic [4:0]         rice_param_reg;
    logic [CNT_W-1:0]   res_count_reg;
    logic [31:0]        bit_count_reg;

    // control and payload state
    state_t             state_reg, state_next;
    logic [7:0]         byte_reg, byte_next;
    logic               last_reg, last_next;
    logic [2:0]         bit_idx_reg, bit_idx_next;
    logic [31:0]        bit_pos_reg, bit_pos_next;
    logic [CNT_W-1:0]   res_done_reg, res_done_next;
    logic [31:0]        quot_reg, quot_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [4:0]         left_reg, left_next;
    logic               in_rem_reg, in_rem_next;
    status_t            error_reg, error_next;
    logic [BSEEN_W-1:0] bseen_reg, bseen_next;

    // pending residual and output register
    logic               pend_valid_reg, pend_valid_next;
    logic [31:0]        pend_res_reg, pend_res_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_res_reg, out_res_next;
    logic               out_is_st_reg, out_is_st_next;
    status_t            out_st_reg, out_st_next;
    logic               out_last_reg, out_last_next;

    // derived values
    logic [4:0]         eff_p;
    logic [CNT_W-1:0]   eff_count;
    logic [BSEEN_W-1:0] exp_bytes;
    logic [32:0]        bit_sum;
    logic [BSEEN_W-1:0] bseen_inc;
    logic               can_load;
    logic               cfg_wr;

    // one-bit step
    logic               cur_bit;
    logic               emit;
    logic [31:0]        quot_step;
    logic [ACC_W-1:0]   acc_step;
    logic [4:0]         left_step;
    logic               in_rem_step;
    logic [31:0]        code;
    logic [31:0]        res_step;

    // end-of-payload status
    logic [7:0]         pad_mask;
    status_t            final_st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rice_param_reg <= '0;
            res_count_reg  <= '0;
            bit_count_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_RICE_PARAM: rice_param_reg <= pwdata[4:0];
                REG_RES_COUNT:  res_count_reg  <= pwdata[CNT_W-1:0];
                REG_BIT_COUNT:  bit_count_reg  <= pwdata;
                default:        ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (paddr[3:2])
            REG_RICE_PARAM: prdata = {27'd0, rice_param_reg};
            REG_RES_COUNT:  prdata = {{(32-CNT_W){1'b0}}, res_count_reg};
            REG_BIT_COUNT:  prdata = bit_count_reg;
            default:        prdata = '0;
        endcase
    end

    // Clamp registers and derive the expected byte count
    assign eff_p     = (rice_param_reg > RICE_MAX) ? RICE_MAX : rice_param_reg;
    assign eff_count = (res_count_reg > MAX_CNT) ? MAX_CNT : res_count_reg;
    assign bit_sum   = {1'b0, bit_count_reg} + 33'd7;
    assign exp_bytes = bit_sum[32:3];
    assign bseen_inc = (bseen_reg == BSEEN_MAX) ? bseen_reg : bseen_reg + 1'b1;
    assign can_load  = !out_valid_reg || m_tready;

    // Advance the Rice sequencer by one payload bit
    always_comb
    begin
        cur_bit     = byte_reg[bit_idx_reg];
        emit        = 1'b0;
        quot_step   = quot_reg;
        acc_step    = acc_reg;
        left_step   = left_reg;
        in_rem_step = in_rem_reg;
        if (!in_rem_reg)
        begin
            if (!cur_bit)
            begin
                quot_step = quot_reg + 32'd1;
            end
            else if (eff_p == 5'd0)
            begin
                acc_step = '0;
                emit     = 1'b1;
            end
            else
            begin
                in_rem_step = 1'b1;
                left_step   = eff_p;
                acc_step    = '0;
            end
        end
        else
        begin
            acc_step  = {acc_reg[ACC_W-2:0], cur_bit};
            left_step = (left_reg != 5'd0) ? left_reg - 5'd1 : 5'd0;
            emit      = (left_step == 5'd0);
        end
        code     = (quot_step << eff_p) | {{(32-ACC_W){1'b0}}, acc_step};
        res_step = code[0] ? ~{1'b0, code[31:1]} : {1'b0, code[31:1]};
    end

    // Pick the end-of-payload status
    always_comb
    begin
        pad_mask = 8'hFF >> bit_count_reg[2:0];
        if (bseen_reg != exp_bytes)
            final_st = ST_LENGTH;
        else if (error_reg != ST_OK)
            final_st = error_reg;
        else if (res_done_reg < eff_count)
            final_st = ST_TRUNC;
        else if (bit_pos_reg != bit_count_reg)
            final_st = ST_UNCONSUMED;
        else if ((bit_count_reg[2:0] != 3'd0) && ((byte_reg & pad_mask) != 8'd0))
            final_st = ST_PADDING;
        else
            final_st = ST_OK;
    end

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        bit_idx_next    = bit_idx_reg;
        bit_pos_next    = bit_pos_reg;
        res_done_next   = res_done_reg;
        quot_next       = quot_reg;
        acc_next        = acc_reg;
        left_next       = left_reg;
        in_rem_next     = in_rem_reg;
        error_next      = error_reg;
        bseen_next      = bseen_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        out_is_st_next  = out_is_st_reg;
        out_st_next     = out_st_reg;
        out_last_next   = out_last_reg;

        // drop the output item once taken
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next    = s_tdata;
                    last_next    = s_tlast;
                    bit_idx_next = 3'd7;
                    bseen_next   = bseen_inc;
                    if ((error_reg == ST_OK) && (bseen_inc > exp_bytes))
                        error_next = ST_LENGTH;
                    state_next = S_BITS;
                end
            end

            S_BITS:
            begin
                if ((error_reg != ST_OK) || (res_done_reg >= eff_count))
                begin
                    state_next = S_FLUSH;
                end
                else if (bit_pos_reg >= bit_count_reg)
                begin
                    error_next = ST_TRUNC;
                    state_next = S_FLUSH;
                end
                else if (!in_rem_reg && !cur_bit && (quot_reg == (32'hFFFF_FFFF >> eff_p)))
                begin
                    error_next = ST_QOVF;
                    state_next = S_FLUSH;
                end
                else if (!(emit && pend_valid_reg && !can_load))
                begin
                    // hold when a new residual would have nowhere to go
                    bit_pos_next = bit_pos_reg + 32'd1;
                    if (emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_res_next   = pend_res_reg;
                            out_is_st_next = 1'b0;
                            out_st_next    = ST_OK;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_res_next   = res_step;
                        res_done_next   = res_done_reg + 1'b1;
                        quot_next       = '0;
                        acc_next        = '0;
                        left_next       = '0;
                        in_rem_next     = 1'b0;
                    end
                    else
                    begin
                        quot_next   = quot_step;
                        acc_next    = acc_step;
                        left_next   = left_step;
                        in_rem_next = in_rem_step;
                    end
                    if (bit_idx_reg == 3'd0)
                        state_next = S_FLUSH;
                    else
                        bit_idx_next = bit_idx_reg - 3'd1;
                end
            end

            S_FLUSH:
            begin
                // push the held residual, last of the byte unless a status follows
                if (pend_valid_reg)
                begin
                    if (can_load)
                    begin
                        out_valid_next  = 1'b1;
                        out_res_next    = pend_res_reg;
                        out_is_st_next  = 1'b0;
                        out_st_next     = ST_OK;
                        out_last_next   = !last_reg;
                        pend_valid_next = 1'b0;
                        state_next      = last_reg ? S_STATUS : S_IDLE;
                    end
                end
                else
                begin
                    state_next = last_reg ? S_STATUS : S_IDLE;
                end
            end

            S_STATUS:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = '0;
                    out_is_st_next = 1'b1;
                    out_st_next    = final_st;
                    out_last_next  = 1'b1;
                    // return the payload state to reset values
                    bit_pos_next   = '0;
                    res_done_next  = '0;
                    quot_next      = '0;
                    acc_next       = '0;
                    left_next      = '0;
                    in_rem_next    = 1'b0;
                    error_next     = ST_OK;
                    bseen_next     = '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bit_idx_reg    <= '0;
            bit_pos_reg    <= '0;
            res_done_reg   <= '0;
            quot_reg       <= '0;
            acc_reg        <= '0;
            left_reg       <= '0;
            in_rem_reg     <= 1'b0;
            error_reg      <= ST_OK;
            bseen_reg      <= '0;
            last_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bit_idx_reg    <= bit_idx_next;
            bit_pos_reg    <= bit_pos_next;
            res_done_reg   <= res_done_next;
            quot_reg       <= quot_next;
            acc_reg        <= acc_next;
            left_reg       <= left_next;
            in_rem_reg     <= in_rem_next;
            error_reg      <= error_next;
            bseen_reg      <= bseen_next;
            last_reg       <= last_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        pend_res_reg  <= pend_res_next;
        out_res_reg   <= out_res_next;
        out_is_st_reg <= out_is_st_next;
        out_st_reg    <= out_st_next;
        out_last_reg  <= out_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;
    assign m_tuser  = {out_st_reg, out_is_st_reg};
    assign m_tlast  = out_last_reg;

endmodule
